// ===== rtl/core/gbt_pkg.sv =====
// Package for the graph search block: state encoding, codes and the
// command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package gbt_pkg;

    localparam int VERTEX_LIMIT = 16;

    // Input item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_BFS   = 2'd2;
    localparam logic [1:0] KIND_DFS   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_VISIT = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_DROP  = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    // Register index of vertex_count on the configuration port.
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E_CNT_A,
        ST_E_CNT_B,
        ST_E_CHECK,
        ST_E_APP_A,
        ST_E_APP_B,
        ST_BFS_CHK,
        ST_DFS_CHK,
        ST_B_POP,
        ST_B_LOAD,
        ST_B_SCAN,
        ST_B_TEST,
        ST_D_SCAN,
        ST_D_POP,
        ST_D_TEST,
        ST_FINISH,
        ST_RESP_DONE,
        ST_RESP_DROP,
        ST_RESP_BAD
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clr_cnt;
        logic       cap_ca;
        logic       cap_cb;
        logic       app_a;
        logic       app_b;
        logic       srch_init;
        logic       q_pop;
        logic       load_cur;
        logic       nbr_rd;
        logic       bfs_take;
        logic       dfs_take;
        logic       s_pop;
        logic       fin_push;
        logic       resp_push;
        logic [1:0] resp_code;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic start_ok;
        logic more_nbr;
        logic q_empty;
        logic stk_empty;
        logic take_ok;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/gbt_ctrl.sv =====
// Controller state machine of the graph search block.
// Depends on gbt_pkg; drives commands to gbt_datapath and reads its status.
`timescale 1ns / 1ps

module gbt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      kind,
    input  gbt_pkg::stat_t  stat,
    output logic            in_ready,
    output gbt_pkg::cmd_t   cmd
);

    gbt_pkg::state_t state_reg;
    gbt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        gbt_pkg::KIND_CLEAR: state_next = gbt_pkg::ST_RESP_DONE;
                        gbt_pkg::KIND_EDGE:  state_next = gbt_pkg::ST_E_CNT_A;
                        gbt_pkg::KIND_BFS:   state_next = gbt_pkg::ST_BFS_CHK;
                        default:             state_next = gbt_pkg::ST_DFS_CHK;
                    endcase
                end
            end
            gbt_pkg::ST_E_CNT_A: state_next = gbt_pkg::ST_E_CNT_B;
            gbt_pkg::ST_E_CNT_B: state_next = gbt_pkg::ST_E_CHECK;
            gbt_pkg::ST_E_CHECK:
            begin
                state_next = stat.edge_ok ? gbt_pkg::ST_E_APP_A : gbt_pkg::ST_RESP_DROP;
            end
            gbt_pkg::ST_E_APP_A: state_next = gbt_pkg::ST_E_APP_B;
            gbt_pkg::ST_E_APP_B: state_next = gbt_pkg::ST_RESP_DONE;
            gbt_pkg::ST_BFS_CHK:
            begin
                state_next = stat.start_ok ? gbt_pkg::ST_B_POP : gbt_pkg::ST_RESP_BAD;
            end
            gbt_pkg::ST_DFS_CHK:
            begin
                state_next = stat.start_ok ? gbt_pkg::ST_D_SCAN : gbt_pkg::ST_RESP_BAD;
            end
            gbt_pkg::ST_B_POP:
            begin
                state_next = stat.q_empty ? gbt_pkg::ST_FINISH : gbt_pkg::ST_B_LOAD;
            end
            gbt_pkg::ST_B_LOAD: state_next = gbt_pkg::ST_B_SCAN;
            gbt_pkg::ST_B_SCAN:
            begin
                state_next = stat.more_nbr ? gbt_pkg::ST_B_TEST : gbt_pkg::ST_B_POP;
            end
            gbt_pkg::ST_B_TEST:
            begin
                if (!stat.take_ok || stat.out_free)
                begin
                    state_next = gbt_pkg::ST_B_SCAN;
                end
            end
            gbt_pkg::ST_D_SCAN:
            begin
                if (stat.more_nbr)
                begin
                    state_next = gbt_pkg::ST_D_TEST;
                end
                else if (stat.stk_empty)
                begin
                    state_next = gbt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = gbt_pkg::ST_D_POP;
                end
            end
            gbt_pkg::ST_D_POP: state_next = gbt_pkg::ST_D_SCAN;
            gbt_pkg::ST_D_TEST:
            begin
                if (!stat.take_ok || stat.out_free)
                begin
                    state_next = gbt_pkg::ST_D_SCAN;
                end
            end
            gbt_pkg::ST_FINISH,
            gbt_pkg::ST_RESP_DONE,
            gbt_pkg::ST_RESP_DROP,
            gbt_pkg::ST_RESP_BAD:
            begin
                if (stat.out_free)
                begin
                    state_next = gbt_pkg::ST_IDLE;
                end
            end
            default: state_next = gbt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            gbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                cmd.clr_cnt = in_valid && (kind == gbt_pkg::KIND_CLEAR);
            end
            gbt_pkg::ST_E_CNT_A: cmd.cap_ca = 1'b1;
            gbt_pkg::ST_E_CNT_B: cmd.cap_cb = 1'b1;
            gbt_pkg::ST_E_APP_A: cmd.app_a = 1'b1;
            gbt_pkg::ST_E_APP_B: cmd.app_b = 1'b1;
            gbt_pkg::ST_BFS_CHK,
            gbt_pkg::ST_DFS_CHK: cmd.srch_init = stat.start_ok;
            gbt_pkg::ST_B_POP: cmd.q_pop = !stat.q_empty;
            gbt_pkg::ST_B_LOAD,
            gbt_pkg::ST_D_POP: cmd.load_cur = 1'b1;
            gbt_pkg::ST_B_SCAN: cmd.nbr_rd = stat.more_nbr;
            gbt_pkg::ST_B_TEST: cmd.bfs_take = stat.take_ok && stat.out_free;
            gbt_pkg::ST_D_SCAN:
            begin
                cmd.nbr_rd = stat.more_nbr;
                cmd.s_pop = !stat.more_nbr && !stat.stk_empty;
            end
            gbt_pkg::ST_D_TEST: cmd.dfs_take = stat.take_ok && stat.out_free;
            gbt_pkg::ST_FINISH: cmd.fin_push = stat.out_free;
            gbt_pkg::ST_RESP_DONE:
            begin
                cmd.resp_push = stat.out_free;
                cmd.resp_code = gbt_pkg::STAT_DONE;
            end
            gbt_pkg::ST_RESP_DROP:
            begin
                cmd.resp_push = stat.out_free;
                cmd.resp_code = gbt_pkg::STAT_DROP;
            end
            gbt_pkg::ST_RESP_BAD:
            begin
                cmd.resp_push = stat.out_free;
                cmd.resp_code = gbt_pkg::STAT_BAD;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/gbt_datapath.sv =====
// Datapath of the graph search block: neighbor memory, counts, visited marks,
// queue/stack memory and the result register. Depends on gbt_pkg.
`timescale 1ns / 1ps

module gbt_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gbt_pkg::cmd_t   cmd,
    output gbt_pkg::stat_t  stat,
    input  logic [4:0]      vertex_count,
    input  logic [3:0]      vertex_a,
    input  logic [3:0]      vertex_b,
    output logic [3:0]      visited_vertex,
    output logic [1:0]      status,
    output logic            last,
    output logic            out_valid,
    input  logic            out_ready
);

    localparam int LIM  = (MAX_VERTICES < gbt_pkg::VERTEX_LIMIT) ? MAX_VERTICES
                                                                 : gbt_pkg::VERTEX_LIMIT;
    localparam int AW   = $clog2(LIM);
    localparam int LCW  = $clog2(LIM + 1);
    localparam int CW   = $clog2(MAX_DEGREE + 1);
    localparam int SD   = MAX_VERTICES * MAX_DEGREE;
    localparam int SAW  = $clog2(SD);
    localparam int WIDE = SAW + CW + 5;
    localparam int EW   = 4 + CW;

    logic [3:0]     a_reg;
    logic [3:0]     b_reg;
    logic [CW-1:0]  ca_reg;
    logic [CW-1:0]  cb_reg;
    logic [CW-1:0]  cnt_reg [gbt_pkg::VERTEX_LIMIT];
    logic [gbt_pkg::VERTEX_LIMIT-1:0] vis_reg;
    logic [3:0]     nbr_mem [SD];
    logic [3:0]     nbr_q_reg;
    logic [EW-1:0]  wm_mem [LIM];
    logic [EW-1:0]  wm_q_reg;
    logic [3:0]     cur_v_reg;
    logic [CW-1:0]  cur_p_reg;
    logic [3:0]     pend_reg;
    logic [LCW-1:0] visits_reg;
    logic [LCW-1:0] head_reg;
    logic [LCW-1:0] tail_reg;
    logic [AW-1:0]  sp_reg;
    logic [3:0]     vv_reg;
    logic [1:0]     status_reg;
    logic           last_reg;
    logic           out_valid_reg;

    logic [4:0]     n_eff;
    logic [3:0]     cnt_idx;
    logic [CW-1:0]  cnt_rd;
    logic [3:0]     w;
    logic [3:0]     st_wv;
    logic [CW-1:0]  st_wp;
    logic [WIDE-1:0] st_wide;
    logic [WIDE-1:0] rd_wide;
    logic [SAW-1:0] st_waddr;
    logic [SAW-1:0] st_raddr;
    logic           wm_we;
    logic [AW-1:0]  wm_waddr;
    logic [EW-1:0]  wm_wdata;
    logic [AW-1:0]  wm_raddr;
    logic           push;
    logic           take;

    assign n_eff = (vertex_count > 5'(LIM)) ? 5'(LIM) : vertex_count;
    assign cnt_idx = (cmd.cap_cb || cmd.app_b) ? b_reg : (cmd.cap_ca ? a_reg : cur_v_reg);
    assign cnt_rd = cnt_reg[cnt_idx];
    assign w = nbr_q_reg;

    // Neighbor store addressing: row of the vertex, column of the position.
    assign st_wv = cmd.app_b ? b_reg : a_reg;
    assign st_wp = cmd.app_b ? cnt_rd : ca_reg;
    assign st_wide = WIDE'(st_wv) * WIDE'(MAX_DEGREE) + WIDE'(st_wp);
    assign rd_wide = WIDE'(cur_v_reg) * WIDE'(MAX_DEGREE) + WIDE'(cur_p_reg);
    assign st_waddr = st_wide[SAW-1:0];
    assign st_raddr = rd_wide[SAW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.app_a || cmd.app_b)
        begin
            nbr_mem[st_waddr] <= cmd.app_b ? a_reg : b_reg;
        end
        if (cmd.nbr_rd)
        begin
            nbr_q_reg <= nbr_mem[st_raddr];
        end
    end

    // Queue entries and stack frames share one memory.
    assign take = cmd.bfs_take || cmd.dfs_take;
    assign wm_we = cmd.srch_init || take;
    always_comb
    begin
        wm_waddr = '0;
        wm_wdata = {a_reg, CW'(0)};
        if (cmd.bfs_take)
        begin
            wm_waddr = tail_reg[AW-1:0];
            wm_wdata = {w, CW'(0)};
        end
        else if (cmd.dfs_take)
        begin
            wm_waddr = sp_reg;
            wm_wdata = {cur_v_reg, cur_p_reg};
        end
    end
    assign wm_raddr = cmd.s_pop ? (sp_reg - AW'(1)) : head_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            wm_mem[wm_waddr] <= wm_wdata;
        end
        if (cmd.q_pop || cmd.s_pop)
        begin
            wm_q_reg <= wm_mem[wm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= vertex_a;
            b_reg <= vertex_b;
        end
        if (cmd.cap_ca)
        begin
            ca_reg <= cnt_rd;
        end
        if (cmd.cap_cb)
        begin
            cb_reg <= cnt_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gbt_pkg::VERTEX_LIMIT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.clr_cnt)
        begin
            for (int i = 0; i < gbt_pkg::VERTEX_LIMIT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.app_a)
        begin
            cnt_reg[a_reg] <= ca_reg + CW'(1);
        end
        else if (cmd.app_b)
        begin
            cnt_reg[b_reg] <= cnt_rd + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg <= '0;
            cur_v_reg <= '0;
            cur_p_reg <= '0;
            pend_reg <= '0;
            visits_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            sp_reg <= '0;
        end
        else
        begin
            if (cmd.srch_init)
            begin
                vis_reg <= (gbt_pkg::VERTEX_LIMIT)'(1) << a_reg;
                cur_v_reg <= a_reg;
                cur_p_reg <= '0;
                pend_reg <= a_reg;
                visits_reg <= LCW'(1);
                head_reg <= '0;
                tail_reg <= LCW'(1);
                sp_reg <= '0;
            end
            if (cmd.q_pop)
            begin
                head_reg <= head_reg + LCW'(1);
            end
            if (cmd.s_pop)
            begin
                sp_reg <= sp_reg - AW'(1);
            end
            if (cmd.load_cur)
            begin
                cur_v_reg <= wm_q_reg[EW-1:CW];
                cur_p_reg <= wm_q_reg[CW-1:0];
            end
            if (cmd.nbr_rd)
            begin
                cur_p_reg <= cur_p_reg + CW'(1);
            end
            if (take)
            begin
                vis_reg[w] <= 1'b1;
                pend_reg <= w;
                visits_reg <= visits_reg + LCW'(1);
            end
            if (cmd.bfs_take)
            begin
                tail_reg <= tail_reg + LCW'(1);
            end
            if (cmd.dfs_take)
            begin
                sp_reg <= sp_reg + AW'(1);
                cur_v_reg <= w;
                cur_p_reg <= '0;
            end
        end
    end

    // Result register; a visit is held back one step so the last flag is known.
    assign push = take || cmd.fin_push || cmd.resp_push;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            vv_reg <= cmd.resp_push ? 4'd0 : pend_reg;
            status_reg <= cmd.resp_push ? cmd.resp_code : gbt_pkg::STAT_VISIT;
            last_reg <= cmd.fin_push || cmd.resp_push;
        end
    end

    assign visited_vertex = vv_reg;
    assign status = status_reg;
    assign last = last_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.out_free = !out_valid_reg || out_ready;
        stat.start_ok = {1'b0, a_reg} < n_eff;
        if (a_reg == b_reg)
        begin
            stat.edge_ok = ((CW + 1)'(ca_reg) + (CW + 1)'(2)) <= (CW + 1)'(MAX_DEGREE);
        end
        else
        begin
            stat.edge_ok = (ca_reg < CW'(MAX_DEGREE)) && (cb_reg < CW'(MAX_DEGREE));
        end
        stat.edge_ok = stat.edge_ok && ({1'b0, a_reg} < n_eff) && ({1'b0, b_reg} < n_eff);
        stat.more_nbr = cur_p_reg < cnt_rd;
        stat.q_empty = head_reg == tail_reg;
        stat.stk_empty = sp_reg == '0;
        stat.take_ok = ({1'b0, w} < n_eff) && !vis_reg[w] && (visits_reg < LCW'(LIM));
    end

endmodule

// ===== rtl/core/graph_bfs_dfs_traversal.sv =====
// Top level of the graph search block: configuration register, controller
// and datapath. Depends on gbt_pkg, gbt_ctrl and gbt_datapath.
`timescale 1ns / 1ps

// The block stores an undirected graph of up to 16 vertices as neighbor lists
// and runs breadth-first or depth-first searches over it, one request at a
// time. A search walks the stored neighbor entries one at a time through the
// single read port of the neighbor memory. Each search result is reported
// only once the next visit is found or the search ends, so that the final
// visit can carry the last flag. A new request is taken only once the
// previous one has put out its last result; a result may still wait in the
// output register while the next request is taken. vertex_count sits at byte
// address 0 of the configuration port and must only be written while the
// block is idle.

module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  vertex_a,
    input  logic [3:0]  vertex_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  visited_vertex,
    output logic [1:0]  status,
    output logic        last
);

    logic [4:0]     vertex_count_reg;
    logic           cfg_wr;
    gbt_pkg::cmd_t  cmd;
    gbt_pkg::stat_t stat;

    // The register is written in the access phase of an APB write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3:2] == gbt_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 5'd16;
        end
        else if (cfg_wr)
        begin
            vertex_count_reg <= pwdata[4:0];
        end
    end

    // Reads of any other address return zero.
    assign prdata = (paddr[3:2] == gbt_pkg::REG_VERTEX_COUNT) ? {27'd0, vertex_count_reg}
                                                              : 32'd0;

    // The controller sequences every request; the datapath holds the graph and search storage.
    gbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gbt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .vertex_count   (vertex_count_reg),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .visited_vertex (visited_vertex),
        .status         (status),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

// ===== tb/graph_bfs_dfs_traversal_tb.sv =====
// Self-checking testbench for the graph search block: directed and random
// requests checked against a behavioral graph model. Depends on gbt_pkg and graph_bfs_dfs_traversal.
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_tb;

    localparam int NV = 16;
    localparam int ND = 8;

    typedef struct packed {
        logic [3:0] vtx;
        logic [1:0] stat;
        logic       lst;
    } visit_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] a;
        logic [3:0] b;
        logic       has_exp;
        logic [1:0] exp_stat;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [3:0]  vertex_a;
    logic [3:0]  vertex_b;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  visited_vertex;
    logic [1:0]  status;
    logic        last;

    // Shadow of the graph kept by the predictor.
    logic [3:0] adj [NV][ND];
    int         deg [NV];
    int         live_n;

    visit_t     expected_visits[$];
    int         errors = 0;
    int         table_errors;
    int         hold_cycles;
    logic       hold_start;
    logic       req_open;
    logic [1:0] first_stat;

    graph_bfs_dfs_traversal DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far above the slowest legal run, including all long stalls.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Push one expected result.
    function automatic void expect_visit(logic [3:0] v, logic [1:0] s, logic l);
        visit_t e;
        e.vtx = v;
        e.stat = s;
        e.lst = l;
        if (req_open)
        begin
            first_stat = s;
            req_open = 1'b0;
        end
        expected_visits.push_back(e);
    endfunction

    // Predict all results of one request and update the graph shadow.
    function automatic void predict_request(logic [1:0] k, int a, int b);
        logic [3:0] found [$];
        bit         mark [NV];
        int         fifo [$];
        int         stk_v [$];
        int         stk_p [$];
        int         v;
        int         w;
        int         p;
        found = {};
        req_open = 1'b1;
        if (k == gbt_pkg::KIND_CLEAR)
        begin
            foreach (deg[i]) deg[i] = 0;
            expect_visit(4'd0, gbt_pkg::STAT_DONE, 1'b1);
            return;
        end
        if (k == gbt_pkg::KIND_EDGE)
        begin
            if (a >= live_n || b >= live_n)
                expect_visit(4'd0, gbt_pkg::STAT_DROP, 1'b1);
            else if ((a == b && deg[a] + 2 > ND) ||
                     (a != b && (deg[a] >= ND || deg[b] >= ND)))
                expect_visit(4'd0, gbt_pkg::STAT_DROP, 1'b1);
            else
            begin
                adj[a][deg[a]] = 4'(b);
                deg[a]++;
                adj[b][deg[b]] = 4'(a);
                deg[b]++;
                expect_visit(4'd0, gbt_pkg::STAT_DONE, 1'b1);
            end
            return;
        end
        if (a >= live_n)
        begin
            expect_visit(4'd0, gbt_pkg::STAT_BAD, 1'b1);
            return;
        end
        foreach (mark[i]) mark[i] = 1'b0;
        mark[a] = 1'b1;
        found.push_back(4'(a));
        if (k == gbt_pkg::KIND_BFS)
        begin
            fifo.push_back(a);
            while (fifo.size() > 0)
            begin
                v = fifo.pop_front();
                for (int j = 0; j < deg[v]; j++)
                begin
                    w = int'(adj[v][j]);
                    if (w < live_n && !mark[w])
                    begin
                        mark[w] = 1'b1;
                        fifo.push_back(w);
                        found.push_back(4'(w));
                    end
                end
            end
        end
        else
        begin
            // Explicit stack of (vertex, next neighbor position).
            stk_v.push_back(a);
            stk_p.push_back(0);
            while (stk_v.size() > 0)
            begin
                v = stk_v[$];
                p = stk_p[$];
                if (p < deg[v])
                begin
                    w = int'(adj[v][p]);
                    stk_p[$] = p + 1;
                    if (w < live_n && !mark[w])
                    begin
                        mark[w] = 1'b1;
                        found.push_back(4'(w));
                        stk_v.push_back(w);
                        stk_p.push_back(0);
                    end
                end
                else
                begin
                    void'(stk_v.pop_back());
                    void'(stk_p.pop_back());
                end
            end
        end
        foreach (found[i])
            expect_visit(found[i], gbt_pkg::STAT_VISIT, i == found.size() - 1);
    endfunction

    // Result checker; the receiver stalls at random and honors hold-offs.
    always @(posedge clk)
    begin
        visit_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_visits.size() == 0)
            begin
                $display("%0t: unexpected result vtx=%0d status=%0d last=%0d",
                         $time, visited_vertex, status, last);
                errors++;
            end
            else
            begin
                e = expected_visits.pop_front();
                if (e.vtx !== visited_vertex || e.stat !== status || e.lst !== last)
                begin
                    $display("%0t: mismatch expected vtx=%0d status=%0d last=%0d, actual vtx=%0d status=%0d last=%0d",
                             $time, e.vtx, e.stat, e.lst, visited_vertex, status, last);
                    errors++;
                end
            end
        end
    end

    // Receiver ready: runs of random stalls, long ones now and then.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_start)
        begin
            hold_cycles <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 8)
            hold_cycles <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_vertex_count(int value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {gbt_pkg::REG_VERTEX_COUNT, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        live_n = (value > NV) ? NV : value;
    endtask

    // Wait until all results are in, then a quiet stretch.
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_visits.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Offer one request, with a random gap before it.
    task automatic send_request(logic [1:0] k, logic [3:0] a, logic [3:0] b);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 15) == 0) ?
              $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        vertex_a <= a;
        vertex_b <= b;
        predict_request(k, int'(a), int'(b));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random request; edges dominate to build connected graphs.
    task automatic random_request(int n);
        int         r;
        logic [1:0] k;
        r = $urandom_range(0, 99);
        if (r < 3)
            k = gbt_pkg::KIND_CLEAR;
        else if (r < 60)
            k = gbt_pkg::KIND_EDGE;
        else
            k = (r < 80) ? gbt_pkg::KIND_BFS : gbt_pkg::KIND_DFS;
        if ($urandom_range(0, 9) == 0)
            send_request(k, 4'($urandom), 4'($urandom));
        else
            send_request(k, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)));
    endtask

    row_t directed [] = '{
        '{gbt_pkg::KIND_BFS,   4'd0,  4'd0,  1'b1, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_DFS,   4'd15, 4'd0,  1'b1, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_EDGE,  4'd0,  4'd15, 1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd0,  4'd1,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd1,  4'd2,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd2,  4'd2,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd15, 4'd14, 1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_BFS,   4'd0,  4'd9,  1'b0, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_DFS,   4'd0,  4'd9,  1'b0, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd4,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd5,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd6,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd7,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd8,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd9,  1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd10, 1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd3,  1'b1, gbt_pkg::STAT_DROP},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd11, 1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_EDGE,  4'd3,  4'd12, 1'b1, gbt_pkg::STAT_DROP},
        '{gbt_pkg::KIND_DFS,   4'd3,  4'd0,  1'b0, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_BFS,   4'd15, 4'd0,  1'b0, gbt_pkg::STAT_VISIT},
        '{gbt_pkg::KIND_CLEAR, 4'd15, 4'd15, 1'b1, gbt_pkg::STAT_DONE},
        '{gbt_pkg::KIND_BFS,   4'd7,  4'd0,  1'b1, gbt_pkg::STAT_VISIT}
    };

    initial
    begin
        int n;
        table_errors = 0;
        hold_start = 1'b0;
        req_open = 1'b0;
        first_stat = gbt_pkg::STAT_VISIT;
        live_n = NV;
        foreach (deg[i]) deg[i] = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        kind = gbt_pkg::KIND_CLEAR;
        vertex_a = '0;
        vertex_b = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Typed expectations are checked against the model's
        // first result, so a wrong model would be caught too.
        foreach (directed[i])
        begin
            send_request(directed[i].kind, directed[i].a, directed[i].b);
            if (directed[i].has_exp && first_stat !== directed[i].exp_stat)
            begin
                $display("%0t: table row %0d expected status %0d, model %0d",
                         $time, i, directed[i].exp_stat, first_stat);
                table_errors++;
            end
        end
        drain();

        // Long receiver hold-off while requests keep coming.
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 12; i++)
            random_request(NV);
        drain();

        // Lowered count: stale neighbors, zero count, one vertex, then wide.
        write_vertex_count(6);
        for (int i = 0; i < 20; i++)
            random_request(NV);
        drain();
        write_vertex_count(0);
        send_request(gbt_pkg::KIND_EDGE, 4'd0, 4'd0);
        send_request(gbt_pkg::KIND_BFS, 4'd0, 4'd0);
        send_request(gbt_pkg::KIND_DFS, 4'd0, 4'd0);
        drain();
        write_vertex_count(1);
        send_request(gbt_pkg::KIND_EDGE, 4'd0, 4'd0);
        send_request(gbt_pkg::KIND_DFS, 4'd0, 4'd0);
        send_request(gbt_pkg::KIND_BFS, 4'd1, 4'd0);
        drain();
        write_vertex_count(31);

        for (int ph = 0; ph < 6; ph++)
        begin
            n = (ph % 2 == 0) ? NV : $urandom_range(2, NV);
            write_vertex_count((ph == 5) ? 16 : n);
            for (int i = 0; i < 45; i++)
                random_request(live_n);
            drain();
        end

        if (errors == 0 && table_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
